// File: src/rv32i_instruction_decoder_defines.svh
// Shared assertion macros for the decoder.
`ifndef RV32I_INSTRUCTION_DECODER_DEFINES_SVH
`define RV32I_INSTRUCTION_DECODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RID_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("decoder check failed");

// Next-cycle implication, checked out of reset.
`define RID_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("decoder check failed");

`endif

// File: src/rid_pkg.sv
package rid_pkg;

    localparam int INSN_W = 32;
    localparam int CODE_W = 6;
    localparam int REG_W  = 5;

    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;

    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;

    localparam logic [2:0] F3_0 = 3'd0;
    localparam logic [2:0] F3_1 = 3'd1;
    localparam logic [2:0] F3_2 = 3'd2;
    localparam logic [2:0] F3_3 = 3'd3;
    localparam logic [2:0] F3_4 = 3'd4;
    localparam logic [2:0] F3_5 = 3'd5;
    localparam logic [2:0] F3_6 = 3'd6;
    localparam logic [2:0] F3_7 = 3'd7;

    localparam logic [CODE_W-1:0] MN_UNKNOWN = 6'd0;
    localparam logic [CODE_W-1:0] MN_ADD   = 6'd1;
    localparam logic [CODE_W-1:0] MN_SUB   = 6'd2;
    localparam logic [CODE_W-1:0] MN_SLL   = 6'd3;
    localparam logic [CODE_W-1:0] MN_SLT   = 6'd4;
    localparam logic [CODE_W-1:0] MN_SLTU  = 6'd5;
    localparam logic [CODE_W-1:0] MN_XOR   = 6'd6;
    localparam logic [CODE_W-1:0] MN_SRL   = 6'd7;
    localparam logic [CODE_W-1:0] MN_SRA   = 6'd8;
    localparam logic [CODE_W-1:0] MN_OR    = 6'd9;
    localparam logic [CODE_W-1:0] MN_AND   = 6'd10;
    localparam logic [CODE_W-1:0] MN_JALR  = 6'd11;
    localparam logic [CODE_W-1:0] MN_LB    = 6'd12;
    localparam logic [CODE_W-1:0] MN_LH    = 6'd13;
    localparam logic [CODE_W-1:0] MN_LW    = 6'd14;
    localparam logic [CODE_W-1:0] MN_LBU   = 6'd15;
    localparam logic [CODE_W-1:0] MN_LHU   = 6'd16;
    localparam logic [CODE_W-1:0] MN_ADDI  = 6'd17;
    localparam logic [CODE_W-1:0] MN_SLTI  = 6'd18;
    localparam logic [CODE_W-1:0] MN_SLTIU = 6'd19;
    localparam logic [CODE_W-1:0] MN_XORI  = 6'd20;
    localparam logic [CODE_W-1:0] MN_ORI   = 6'd21;
    localparam logic [CODE_W-1:0] MN_ANDI  = 6'd22;
    localparam logic [CODE_W-1:0] MN_SLLI  = 6'd23;
    localparam logic [CODE_W-1:0] MN_SRLI  = 6'd24;
    localparam logic [CODE_W-1:0] MN_SRAI  = 6'd25;
    localparam logic [CODE_W-1:0] MN_SB    = 6'd26;
    localparam logic [CODE_W-1:0] MN_SH    = 6'd27;
    localparam logic [CODE_W-1:0] MN_SW    = 6'd28;
    localparam logic [CODE_W-1:0] MN_BEQ   = 6'd29;
    localparam logic [CODE_W-1:0] MN_BNE   = 6'd30;
    localparam logic [CODE_W-1:0] MN_BLT   = 6'd31;
    localparam logic [CODE_W-1:0] MN_BGE   = 6'd32;
    localparam logic [CODE_W-1:0] MN_BLTU  = 6'd33;
    localparam logic [CODE_W-1:0] MN_BGEU  = 6'd34;
    localparam logic [CODE_W-1:0] MN_LUI   = 6'd35;
    localparam logic [CODE_W-1:0] MN_AUIPC = 6'd36;
    localparam logic [CODE_W-1:0] MN_JAL   = 6'd37;

    typedef struct packed {
        logic [CODE_W-1:0]        mnemonic_code;
        logic [REG_W-1:0]         dest_reg;
        logic [REG_W-1:0]         src1_reg;
        logic [REG_W-1:0]         src2_reg;
        logic signed [INSN_W-1:0] immediate;
    } result_t;

    function automatic logic [CODE_W-1:0] r_code(input logic [2:0] f3, input logic alt);
        logic [CODE_W-1:0] c;
        c = MN_UNKNOWN;
        case (f3)
            F3_0:    c = alt ? MN_SUB : MN_ADD;
            F3_1:    c = alt ? MN_UNKNOWN : MN_SLL;
            F3_2:    c = alt ? MN_UNKNOWN : MN_SLT;
            F3_3:    c = alt ? MN_UNKNOWN : MN_SLTU;
            F3_4:    c = alt ? MN_UNKNOWN : MN_XOR;
            F3_5:    c = alt ? MN_SRA : MN_SRL;
            F3_6:    c = alt ? MN_UNKNOWN : MN_OR;
            F3_7:    c = alt ? MN_UNKNOWN : MN_AND;
            default: c = MN_UNKNOWN;
        endcase
        return c;
    endfunction

    function automatic logic [CODE_W-1:0] load_code(input logic [2:0] f3);
        logic [CODE_W-1:0] c;
        c = MN_UNKNOWN;
        case (f3)
            F3_0:    c = MN_LB;
            F3_1:    c = MN_LH;
            F3_2:    c = MN_LW;
            F3_4:    c = MN_LBU;
            F3_5:    c = MN_LHU;
            default: c = MN_UNKNOWN;
        endcase
        return c;
    endfunction

    function automatic logic [CODE_W-1:0] opimm_code(input logic [2:0] f3);
        logic [CODE_W-1:0] c;
        c = MN_UNKNOWN;
        case (f3)
            F3_0:    c = MN_ADDI;
            F3_2:    c = MN_SLTI;
            F3_3:    c = MN_SLTIU;
            F3_4:    c = MN_XORI;
            F3_6:    c = MN_ORI;
            F3_7:    c = MN_ANDI;
            default: c = MN_UNKNOWN;
        endcase
        return c;
    endfunction

    function automatic logic [CODE_W-1:0] store_code(input logic [2:0] f3);
        logic [CODE_W-1:0] c;
        c = MN_UNKNOWN;
        case (f3)
            F3_0:    c = MN_SB;
            F3_1:    c = MN_SH;
            F3_2:    c = MN_SW;
            default: c = MN_UNKNOWN;
        endcase
        return c;
    endfunction

    function automatic logic [CODE_W-1:0] branch_code(input logic [2:0] f3);
        logic [CODE_W-1:0] c;
        c = MN_UNKNOWN;
        case (f3)
            F3_0:    c = MN_BEQ;
            F3_1:    c = MN_BNE;
            F3_4:    c = MN_BLT;
            F3_5:    c = MN_BGE;
            F3_6:    c = MN_BLTU;
            F3_7:    c = MN_BGEU;
            default: c = MN_UNKNOWN;
        endcase
        return c;
    endfunction

endpackage

// File: src/rid_stage.sv
`include "rv32i_instruction_decoder_defines.svh"

module rid_stage #(
    parameter int WIDTH = rid_pkg::INSN_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic             valid_reg;
    logic             valid_next;
    logic [WIDTH-1:0] data_reg;
    logic [WIDTH-1:0] data_next;

    // stage refills in the same cycle its word leaves
    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (in_ready) begin
            valid_next = in_valid;
            data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    `RID_ASSERT_NEXT(a_load_sets_valid, aclk, aresetn, in_valid && in_ready, valid_reg)
    `RID_ASSERT_NEXT(a_stall_holds, aclk, aresetn, valid_reg && !out_ready,
        valid_reg && $stable(data_reg))
    `RID_ASSERT_NEXT(a_no_phantom, aclk, aresetn, !valid_reg && !in_valid, !valid_reg)

endmodule

// File: src/rid_decode.sv
module rid_decode (
    input  logic [rid_pkg::INSN_W-1:0] insn,
    output rid_pkg::result_t           res
);

    logic [6:0]                  opc;
    logic [2:0]                  f3;
    logic [6:0]                  f7;
    logic [rid_pkg::REG_W-1:0]   rd;
    logic [rid_pkg::REG_W-1:0]   rs1;
    logic [rid_pkg::REG_W-1:0]   rs2;
    logic [rid_pkg::INSN_W-1:0]  imm_i;
    logic [rid_pkg::INSN_W-1:0]  imm_s;
    logic [rid_pkg::INSN_W-1:0]  imm_b;
    logic [rid_pkg::INSN_W-1:0]  imm_u;
    logic [rid_pkg::INSN_W-1:0]  imm_j;
    logic [rid_pkg::INSN_W-1:0]  shamt;
    logic [rid_pkg::CODE_W-1:0]  code;
    logic [rid_pkg::REG_W-1:0]   o_rd;
    logic [rid_pkg::REG_W-1:0]   o_rs1;
    logic [rid_pkg::REG_W-1:0]   o_rs2;
    logic [rid_pkg::INSN_W-1:0]  o_imm;

    assign opc = insn[6:0];
    assign rd  = insn[11:7];
    assign f3  = insn[14:12];
    assign rs1 = insn[19:15];
    assign rs2 = insn[24:20];
    assign f7  = insn[31:25];

    assign imm_i = {{20{insn[31]}}, insn[31:20]};
    assign imm_s = {{20{insn[31]}}, insn[31:25], insn[11:7]};
    assign imm_b = {{19{insn[31]}}, insn[31], insn[7], insn[30:25], insn[11:8], 1'b0};
    assign imm_u = {insn[31:12], 12'b0};
    assign imm_j = {{11{insn[31]}}, insn[31], insn[19:12], insn[20], insn[30:21], 1'b0};
    assign shamt = {27'b0, insn[24:20]};

    always_comb begin
        code  = rid_pkg::MN_UNKNOWN;
        o_rd  = '0;
        o_rs1 = '0;
        o_rs2 = '0;
        o_imm = '0;
        case (opc)
            rid_pkg::OPC_OP: begin
                if (f7 == rid_pkg::F7_BASE) begin
                    code = rid_pkg::r_code(f3, 1'b0);
                end else if (f7 == rid_pkg::F7_ALT) begin
                    code = rid_pkg::r_code(f3, 1'b1);
                end
                o_rd  = rd;
                o_rs1 = rs1;
                o_rs2 = rs2;
            end
            rid_pkg::OPC_JALR: begin
                if (f3 == rid_pkg::F3_0) begin
                    code = rid_pkg::MN_JALR;
                end
                o_rd  = rd;
                o_rs1 = rs1;
                o_imm = imm_i;
            end
            rid_pkg::OPC_LOAD: begin
                code  = rid_pkg::load_code(f3);
                o_rd  = rd;
                o_rs1 = rs1;
                o_imm = imm_i;
            end
            rid_pkg::OPC_OPIMM: begin
                o_rd  = rd;
                o_rs1 = rs1;
                if (f3 == rid_pkg::F3_1) begin
                    if (f7 == rid_pkg::F7_BASE) begin
                        code = rid_pkg::MN_SLLI;
                    end
                    o_imm = shamt;
                end else if (f3 == rid_pkg::F3_5) begin
                    if (f7 == rid_pkg::F7_BASE) begin
                        code = rid_pkg::MN_SRLI;
                    end else if (f7 == rid_pkg::F7_ALT) begin
                        code = rid_pkg::MN_SRAI;
                    end
                    o_imm = shamt;
                end else begin
                    code  = rid_pkg::opimm_code(f3);
                    o_imm = imm_i;
                end
            end
            rid_pkg::OPC_STORE: begin
                code  = rid_pkg::store_code(f3);
                o_rs1 = rs1;
                o_rs2 = rs2;
                o_imm = imm_s;
            end
            rid_pkg::OPC_BRANCH: begin
                code  = rid_pkg::branch_code(f3);
                o_rs1 = rs1;
                o_rs2 = rs2;
                o_imm = imm_b;
            end
            rid_pkg::OPC_LUI: begin
                code  = rid_pkg::MN_LUI;
                o_rd  = rd;
                o_imm = imm_u;
            end
            rid_pkg::OPC_AUIPC: begin
                code  = rid_pkg::MN_AUIPC;
                o_rd  = rd;
                o_imm = imm_u;
            end
            rid_pkg::OPC_JAL: begin
                code  = rid_pkg::MN_JAL;
                o_rd  = rd;
                o_imm = imm_j;
            end
            default: begin
                code = rid_pkg::MN_UNKNOWN;
            end
        endcase
    end

    // unknown words report all-zero fields
    always_comb begin
        res.mnemonic_code = code;
        if (code == rid_pkg::MN_UNKNOWN) begin
            res.dest_reg  = '0;
            res.src1_reg  = '0;
            res.src2_reg  = '0;
            res.immediate = '0;
        end else begin
            res.dest_reg  = o_rd;
            res.src1_reg  = o_rs1;
            res.src2_reg  = o_rs2;
            res.immediate = o_imm;
        end
    end

endmodule

// File: src/rv32i_instruction_decoder.sv
// Channel  Direction  Ports
// s_       in         s_valid, s_ready, s_instruction_word
// m_       out        m_valid, m_ready, m_mnemonic_code, m_dest_reg, m_src1_reg,
//                     m_src2_reg, m_immediate
//
// Result path from the accepting edge: input register, decode, result register.
// Throughput one word per cycle while m_ready is high; each register refills in the cycle its word leaves.
// aresetn is synchronous, active low, and clears both valid flags.
// A stall on m_ready backs up through both stages to s_ready in the same cycle.
`include "rv32i_instruction_decoder_defines.svh"

module rv32i_instruction_decoder (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [rid_pkg::INSN_W-1:0]         s_instruction_word,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [rid_pkg::CODE_W-1:0]         m_mnemonic_code,
    output logic [rid_pkg::REG_W-1:0]          m_dest_reg,
    output logic [rid_pkg::REG_W-1:0]          m_src1_reg,
    output logic [rid_pkg::REG_W-1:0]          m_src2_reg,
    output logic signed [rid_pkg::INSN_W-1:0]  m_immediate
);

    localparam int RES_W = $bits(rid_pkg::result_t);

    logic                       insn_valid;
    logic                       insn_ready;
    logic [rid_pkg::INSN_W-1:0] insn;
    rid_pkg::result_t           dec_res;
    rid_pkg::result_t           out_res;
    logic [RES_W-1:0]           out_data;

    rid_stage #(
        .WIDTH(rid_pkg::INSN_W)
    ) u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_instruction_word),
        .out_valid (insn_valid),
        .out_ready (insn_ready),
        .out_data  (insn)
    );

    rid_decode u_decode (
        .insn (insn),
        .res  (dec_res)
    );

    rid_stage #(
        .WIDTH(RES_W)
    ) u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (insn_valid),
        .in_ready  (insn_ready),
        .in_data   (dec_res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign out_res         = out_data;
    assign m_mnemonic_code = out_res.mnemonic_code;
    assign m_dest_reg      = out_res.dest_reg;
    assign m_src1_reg      = out_res.src1_reg;
    assign m_src2_reg      = out_res.src2_reg;
    assign m_immediate     = out_res.immediate;

    `RID_ASSERT_NOW(a_unknown_zero, aclk, aresetn,
        m_valid && (m_mnemonic_code == rid_pkg::MN_UNKNOWN),
        (m_dest_reg == '0) && (m_src1_reg == '0) && (m_src2_reg == '0) && (m_immediate == '0))
    `RID_ASSERT_NOW(a_code_range, aclk, aresetn, m_valid, m_mnemonic_code <= rid_pkg::MN_JAL)
    `RID_ASSERT_NEXT(a_word_moves_on, aclk, aresetn, insn_valid && insn_ready, m_valid)

endmodule
